@@ rtl/core/hsv_to_rgb_converter_macros.svh @@
// Assertion macros for the HSV to RGB converter checker.
// Depends on nothing; included by the checker file, which holds the assertions.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define HSV_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Assertion that is also checked during reset.
`define HSV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/hsv2rgb_pkg.sv @@
// Types and constants for the HSV to RGB converter.
// Used by the converter top level and its port checker; depends on nothing.
package hsv2rgb_pkg;

    localparam int BYTE_W = 8;
    localparam int OUT_W  = 3 * BYTE_W;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

    // Color wheel sector; codes six and seven never occur.
    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

endpackage

@@ rtl/core/hsv_to_rgb_converter.sv @@
// Throughput: one item per cycle while the output is not stalled, set by five register
// stages with two multiplier ranks (s*f and s*(1-f) products, then the p/q/t products),
// each stage able to advance alone. A stalled output holds its item; empty stages still
// take new items.
// Reset (aresetn low, synchronous) clears all stage valid bits.
module hsv_to_rgb_converter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // s_tdata, low bit up: hue_frac, sat_frac, val_frac, zero fill to a byte
    input  logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0]       s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // m_tdata, low bit up: red_byte, green_byte, blue_byte
    output logic [hsv2rgb_pkg::OUT_W-1:0]              m_tdata
);

    localparam int FW    = FRAC_BITS + 1;
    localparam int H6W   = FRAC_BITS + 3;
    localparam int PW    = 2 * FRAC_BITS + 1;
    localparam int ACC_W = PW + 9;

    localparam logic [FW-1:0]    ONE      = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [ACC_W-1:0] HALF_SQ  = ACC_W'(1) << (2 * FRAC_BITS - 1);

    // Rounds a Q.2F fraction to floor(x*255 + 1/2), clamped to a byte.
    function automatic logic [hsv2rgb_pkg::BYTE_W-1:0] to_byte(input logic [PW-1:0] x);
        logic [ACC_W-1:0] acc;
        logic [9:0]       whole;
        acc   = ACC_W'({x, 8'h00}) - ACC_W'(x) + HALF_SQ;
        whole = acc[ACC_W-1 -: 10];
        to_byte = (whole > 10'(hsv2rgb_pkg::BYTE_MAX)) ? hsv2rgb_pkg::BYTE_MAX
                                                        : whole[7:0];
    endfunction

    // Stage enables: a stage loads when it is empty or its successor moves.
    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign en5 = !v5_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: clamp the fractions and form hue times six.
    logic [FW-1:0]  hue_in, sat_in, val_in;
    logic [FW-1:0]  hue_clamp, sat_clamp, val_clamp;
    logic [H6W-1:0] h6_next, h6_reg;
    logic [FW-1:0]  s1_sat_reg, s1_val_reg;

    assign hue_in = s_tdata[0 +: FW];
    assign sat_in = s_tdata[FW +: FW];
    assign val_in = s_tdata[2*FW +: FW];

    always_comb begin
        hue_clamp = (hue_in > ONE) ? ONE : hue_in;
        sat_clamp = (sat_in > ONE) ? ONE : sat_in;
        val_clamp = (val_in > ONE) ? ONE : val_in;
        h6_next   = H6W'({hue_clamp, 2'b00}) + H6W'({hue_clamp, 1'b0});
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            h6_reg     <= h6_next;
            s1_sat_reg <= sat_clamp;
            s1_val_reg <= val_clamp;
        end
    end

    // Stage 2: sector and fraction within the sector; hue of one lands in sector five.
    logic [2:0]           sector_raw;
    hsv2rgb_pkg::sector_t sector_next, s2_sector_reg;
    logic [H6W-1:0]       f_wide;
    logic [FW-1:0]        f_next, f_reg, fc_next, fc_reg;
    logic [FW-1:0]        s2_sat_reg, s2_val_reg;

    always_comb begin
        sector_raw  = h6_reg[H6W-1 -: 3];
        sector_next = (sector_raw >= 3'd6) ? hsv2rgb_pkg::SECTOR_5
                                           : hsv2rgb_pkg::sector_t'(sector_raw);
        f_wide      = h6_reg - {sector_next, {FRAC_BITS{1'b0}}};
        f_next      = f_wide[FW-1:0];
        fc_next     = ONE - f_next;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_sector_reg <= sector_next;
            f_reg         <= f_next;
            fc_reg        <= fc_next;
            s2_sat_reg    <= s1_sat_reg;
            s2_val_reg    <= s1_val_reg;
        end
    end

    // Stage 3: s*f and s*(1-f), floored to Q.F.
    logic [2*FW-1:0]      prod_sf, prod_sfc;
    logic [FW-1:0]        sf_reg, sfc_reg, s3_sat_reg, s3_val_reg;
    hsv2rgb_pkg::sector_t s3_sector_reg;

    assign prod_sf  = (2*FW)'(s2_sat_reg) * (2*FW)'(f_reg);
    assign prod_sfc = (2*FW)'(s2_sat_reg) * (2*FW)'(fc_reg);

    always_ff @(posedge aclk) begin
        if (en3) begin
            sf_reg        <= prod_sf[FRAC_BITS +: FW];
            sfc_reg       <= prod_sfc[FRAC_BITS +: FW];
            s3_sat_reg    <= s2_sat_reg;
            s3_val_reg    <= s2_val_reg;
            s3_sector_reg <= s2_sector_reg;
        end
    end

    // Stage 4: p, q and t as exact Q.2F products, v scaled to Q.2F.
    logic [2*FW-1:0]      prod_p, prod_q, prod_t;
    logic [PW-1:0]        p_reg, q_reg, t_reg, vv_reg;
    hsv2rgb_pkg::sector_t s4_sector_reg;

    assign prod_p = (2*FW)'(s3_val_reg) * (2*FW)'(ONE - s3_sat_reg);
    assign prod_q = (2*FW)'(s3_val_reg) * (2*FW)'(ONE - sf_reg);
    assign prod_t = (2*FW)'(s3_val_reg) * (2*FW)'(ONE - sfc_reg);

    always_ff @(posedge aclk) begin
        if (en4) begin
            p_reg         <= prod_p[PW-1:0];
            q_reg         <= prod_q[PW-1:0];
            t_reg         <= prod_t[PW-1:0];
            vv_reg        <= {s3_val_reg, {FRAC_BITS{1'b0}}};
            s4_sector_reg <= s3_sector_reg;
        end
    end

    // Stage 5: pick the terms for each channel and round to bytes.
    logic [PW-1:0] red_x, green_x, blue_x;
    logic [hsv2rgb_pkg::OUT_W-1:0] rgb_next, rgb_reg;

    always_comb begin
        unique case (s4_sector_reg)
            hsv2rgb_pkg::SECTOR_0: begin
                red_x = vv_reg; green_x = t_reg;  blue_x = p_reg;
            end
            hsv2rgb_pkg::SECTOR_1: begin
                red_x = q_reg;  green_x = vv_reg; blue_x = p_reg;
            end
            hsv2rgb_pkg::SECTOR_2: begin
                red_x = p_reg;  green_x = vv_reg; blue_x = t_reg;
            end
            hsv2rgb_pkg::SECTOR_3: begin
                red_x = p_reg;  green_x = q_reg;  blue_x = vv_reg;
            end
            hsv2rgb_pkg::SECTOR_4: begin
                red_x = t_reg;  green_x = p_reg;  blue_x = vv_reg;
            end
            default: begin
                red_x = vv_reg; green_x = p_reg;  blue_x = q_reg;
            end
        endcase
        rgb_next = {to_byte(blue_x), to_byte(green_x), to_byte(red_x)};
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            rgb_reg <= rgb_next;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = rgb_reg;

endmodule

@@ rtl/core/hsv2rgb_checker.sv @@
// Port-level checker for the HSV to RGB converter, bound to its top level.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter_macros.svh.
`include "hsv_to_rgb_converter_macros.svh"

module hsv2rgb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hsv2rgb_pkg::OUT_W-1:0] m_tdata
);

    // A waiting result item keeps its value until it is taken.
    property p_out_hold;
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata);
    endproperty

    // The input side can only be blocked by a full pipeline behind a stalled output.
    property p_ready_only_when_full;
        !s_tready |-> m_tvalid && !m_tready;
    endproperty

    // Reset empties the pipeline.
    property p_reset_empties;
        !aresetn |=> !m_tvalid;
    endproperty

    `HSV_ASSERT_RST(a_out_hold, aclk, aresetn, p_out_hold, "result item changed while stalled")
    `HSV_ASSERT_RST(a_ready_only_when_full, aclk, aresetn, p_ready_only_when_full, "input blocked")
    `HSV_ASSERT_ALWAYS(a_reset_empties, aclk, p_reset_empties, "result item right after reset")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
